### sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/dacc_pkg.sv
package dacc_pkg;

  localparam int DataWidth = 64;
  localparam int CntWidth  = $clog2(DataWidth + 1);

  typedef enum logic [4:0] {
    FN_LOAD = 5'd0, FN_ADD = 5'd1, FN_SUB = 5'd2, FN_MUL = 5'd3, FN_DIV = 5'd4,
    FN_POW = 5'd5, FN_AND = 5'd6, FN_OR = 5'd7, FN_XOR = 5'd8, FN_EQ = 5'd9,
    FN_NE = 5'd10, FN_GT = 5'd11, FN_LT = 5'd12, FN_GE = 5'd13, FN_LE = 5'd14,
    FN_SHL = 5'd15, FN_SHR = 5'd16, FN_INV = 5'd17
  } func_t;

  // shared unit operations
  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_DIV = 2'd1,
    UOP_POW = 2'd2
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

  // shared unit sequencer
  typedef enum logic [2:0] {
    U_IDLE = 3'd0,
    U_MUL  = 3'd1,
    U_DIV  = 3'd2,
    U_PMUL = 3'd3,
    U_PSQ  = 3'd4,
    U_DONE = 3'd5
  } ustate_t;

endpackage

### sv/dacc_unit.sv
`include "assert_macros.svh"

// shift-add multiplier / restoring divider / square-and-multiply power,
// one bit per cycle; power runs two passes of the multiplier per exponent bit
module dacc_unit
  import dacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  unit_req_t            req,
  input  logic [DataWidth-1:0] opd,
  input  logic [DataWidth-1:0] ops,
  output unit_sts_t            sts,
  output logic [DataWidth-1:0] result
);

  ustate_t              state, state_next;
  uop_t                 op;
  logic [CntWidth-1:0]  cnt;
  logic [CntWidth-1:0]  pbit;
  logic [DataWidth-1:0] acc;
  logic [DataWidth-1:0] mcand;
  logic [DataWidth-1:0] mplier;
  logic [DataWidth-1:0] rem;
  logic [DataWidth-1:0] quo;
  logic [DataWidth-1:0] pres;
  logic [DataWidth-1:0] psq;
  logic [DataWidth-1:0] pexp;
  logic [DataWidth:0]   trial;

  assign trial = {rem, quo[DataWidth-1]} - {1'b0, ops};

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE: if (req.start) begin
        case (req.op)
          UOP_MUL: state_next = U_MUL;
          UOP_DIV: state_next = U_DIV;
          UOP_POW: state_next = U_PMUL;
          default: state_next = U_DONE;
        endcase
      end
      U_MUL, U_DIV: if (cnt == CntWidth'(DataWidth - 1)) state_next = U_DONE;
      U_PMUL: if (cnt == CntWidth'(DataWidth - 1)) state_next = U_PSQ;
      U_PSQ: if (cnt == CntWidth'(DataWidth - 1)) begin
        state_next = (pbit == CntWidth'(DataWidth - 1)) ? U_DONE : U_PMUL;
      end
      U_DONE: state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      cnt   <= '0;
      pbit  <= '0;
    end else begin
      state <= state_next;
      if (state == U_IDLE || state_next != state) cnt <= '0;
      else cnt <= cnt + 1'b1;
      if (state == U_IDLE) pbit <= '0;
      else if (state == U_PSQ && state_next != U_PSQ) pbit <= pbit + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        op <= req.op;
        acc <= '0;
        mcand <= opd;
        mplier <= ops;
        rem <= '0;
        quo <= opd;
        pres <= {{(DataWidth-1){1'b0}}, 1'b1};
        psq <= opd;
        pexp <= ops;
        if (req.start && req.op == UOP_POW) begin
          // first pass: pres * psq when exponent bit set
          mcand <= opd;
          mplier <= {{(DataWidth-1){1'b0}}, 1'b1};
        end
      end
      U_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
      end
      U_DIV: begin
        if (!trial[DataWidth]) begin
          rem <= trial[DataWidth-1:0];
          quo <= {quo[DataWidth-2:0], 1'b1};
        end else begin
          rem <= {rem[DataWidth-2:0], quo[DataWidth-1]};
          quo <= {quo[DataWidth-2:0], 1'b0};
        end
      end
      U_PMUL: begin
        if (cnt == '0) begin
          acc <= pres[0] ? psq : '0;
          mcand <= psq << 1;
          mplier <= pres >> 1;
        end else begin
          if (mplier[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
        end
        if (cnt == CntWidth'(DataWidth - 1)) begin
          if (pexp[0]) pres <= mplier[0] ? acc + mcand : acc;
        end
      end
      U_PSQ: begin
        if (cnt == '0) begin
          acc <= psq[0] ? psq : '0;
          mcand <= psq << 1;
          mplier <= psq >> 1;
        end else begin
          if (mplier[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
        end
        if (cnt == CntWidth'(DataWidth - 1)) begin
          psq <= mplier[0] ? acc + mcand : acc;
          pexp <= pexp >> 1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (op)
      UOP_MUL: result = acc;
      UOP_DIV: result = quo;
      default: result = pres;
    endcase
  end

  assign sts.busy = (state != U_IDLE);
  assign sts.done = (state == U_DONE);

  `ASSERT_CLK(a_start_idle, req.start |-> state == U_IDLE, "unit started while busy")
  `ASSERT_CLK(a_done_once, sts.done |=> !sts.done, "done held over two cycles")
  `ASSERT_ALWAYS(a_rst_idle, rst |=> state == U_IDLE, "unit not idle after reset")

endmodule

### sv/dual_accumulator_alu.sv
// dual accumulator alu: executes one decoded register instruction per transfer
// slave channel s_axis: tdata carries func, dest_is_b, src_is_imm, immediate;
// each accepted instruction updates accumulator A or B.
// master channel m_axis: one transfer per instruction with both accumulators
// and the divide-fault flag (1 only for a divide by zero).
// sequencing: each instruction goes from accept to the run state, then to the
// output state; simple operations are computed combinationally in the run state,
// mul and div run on a one-bit-per-cycle shared unit (a divide by zero skips it)
// and pow uses the same unit for multiply and square per exponent bit. one
// instruction is in flight at a time; s_axis_tready is low from accept until the result is taken.
// a stalled m_axis holds its result and the block takes no new instruction.
// reset clears both accumulators to zero and empties the result register.
// shifts use the immediate's low byte; 64 or more gives zero.
`include "assert_macros.svh"

module dual_accumulator_alu
  import dacc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[4:0], dest_is_b[5], src_is_imm[6], immediate[70:7], zero[71]
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // acc_a[63:0], acc_b[127:64], divide_fault[128], zero[135:129]
  output logic [135:0] m_axis_tdata
);

  state_t               state, state_next;
  logic [DataWidth-1:0] accum_a, accum_b;
  logic [4:0]           func;
  logic                 to_b;
  logic [DataWidth-1:0] d, s;
  logic [7:0]           shamt;
  logic                 fault;
  logic [DataWidth-1:0] r;
  logic                 wr;
  logic                 is_unit;
  unit_req_t            ureq;
  unit_sts_t            usts;
  logic [DataWidth-1:0] ures;
  logic                 accept;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    case (func)
      FN_MUL, FN_DIV, FN_POW: is_unit = 1'b1;
      default: is_unit = 1'b0;
    endcase
    ureq.start = (state == ST_RUN) && !usts.busy && is_unit && !(func == FN_DIV && s == '0);
    case (func)
      FN_MUL:  ureq.op = UOP_MUL;
      FN_DIV:  ureq.op = UOP_DIV;
      default: ureq.op = UOP_POW;
    endcase
  end

  dacc_unit u_unit (
    .clk(clk), .rst(rst), .req(ureq), .opd(d), .ops(s), .sts(usts), .result(ures)
  );

  always_comb begin
    r = d;
    wr = 1'b1;
    case (func)
      FN_LOAD: r = s;
      FN_ADD:  r = d + s;
      FN_SUB:  r = d - s;
      FN_MUL, FN_POW: r = ures;
      FN_DIV:  r = (s == '0) ? '1 : ures;
      FN_AND:  r = d & s;
      FN_OR:   r = d | s;
      FN_XOR:  r = d ^ s;
      FN_EQ:   r = DataWidth'(d == s);
      FN_NE:   r = DataWidth'(d != s);
      FN_GT:   r = DataWidth'(d > s);
      FN_LT:   r = DataWidth'(d < s);
      FN_GE:   r = DataWidth'(d >= s);
      FN_LE:   r = DataWidth'(d <= s);
      FN_SHL:  r = (shamt >= 8'(DataWidth)) ? '0 : d << shamt;
      FN_SHR:  r = (shamt >= 8'(DataWidth)) ? '0 : d >> shamt;
      FN_INV:  r = ~d;
      default: wr = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_RUN;
      ST_RUN: begin
        if (!is_unit || (func == FN_DIV && s == '0) || usts.done) state_next = ST_OUT;
      end
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      accum_a <= '0;
      accum_b <= '0;
      fault   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RUN && state_next == ST_OUT) begin
        fault <= (func == FN_DIV) && (s == '0);
        if (wr) begin
          if (to_b) accum_b <= r;
          else accum_a <= r;
        end
      end
    end
  end

  // instruction fields latched at transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      func  <= s_axis_tdata[4:0];
      to_b  <= s_axis_tdata[5];
      shamt <= s_axis_tdata[14:7];
      d     <= s_axis_tdata[5] ? accum_b : accum_a;
      s     <= s_axis_tdata[6] ? s_axis_tdata[70:7]
                               : (s_axis_tdata[5] ? accum_a : accum_b);
    end
  end

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {7'b0, fault, accum_b, accum_a};

  `ASSERT_CLK(a_one_side, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
  `ASSERT_CLK(a_fault_div, m_axis_tvalid && fault |-> func == FN_DIV, "fault without divide")
  `ASSERT_CLK(a_hold_out, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
              "result dropped under stall")

endmodule
